@@ design/pbl_pkg.sv @@
`default_nettype none
package pbl_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [1:0] CFG_USE_RADIUS = 2'd0;
  localparam logic [1:0] CFG_DEN_TOL    = 2'd1;
  localparam logic [1:0] CFG_PARAM_TOL  = 2'd2;

  localparam logic [16:0] PARAM_ONE = 17'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [30:0]        radius;
    logic               new_line;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] min_value;
    logic               found;
    logic [9:0]         segment_index;
    logic [16:0]        seg_param;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        center_radius;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ0,
    ST_READ,
    ST_SEG,
    ST_DIV,
    ST_EVAL,
    ST_NEXT,
    ST_OUT
  } state_e;

  // controller commands to datapath
  typedef struct packed {
    logic load_query;
    logic clr_best;
    logic rd_first;
    logic rd_next;
    logic seg_calc;
    logic div_step;
    logic eval;
    logic update;
  } cmd_t;

  // datapath status to controller
  typedef struct packed {
    logic more;
    logic seg_valid;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

@@ design/pbl_ctrl.sv @@
`default_nettype none
module pbl_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  wire             out_ready_i,
  input  pbl_pkg::stat_t  stat_i,
  output pbl_pkg::cmd_t   cmd_o,
  output logic            busy_o,
  output logic            out_valid_o
);
  import pbl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_query = 1'b1;
          cmd_o.clr_best = 1'b1;
          state_d = ST_READ0;
        end
      end
      ST_READ0: begin
        cmd_o.rd_first = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        if (stat_i.more) begin
          cmd_o.rd_next = 1'b1;
          state_d = ST_SEG;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SEG: begin
        cmd_o.seg_calc = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.seg_valid) begin
          state_d = ST_READ;
        end else if (stat_i.div_done) begin
          state_d = ST_EVAL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.update = 1'b1;
        state_d = ST_READ;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ design/pbl_dp.sv @@
`default_nettype none
module pbl_dp #(
  parameter int MaxVertices = 1024,
  parameter int IdxW = 10
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pbl_pkg::in_item_t   in_i,
  input  wire                 in_fire_i,
  input  pbl_pkg::cmd_t       cmd_i,
  input  wire                 use_radius_i,
  input  wire [15:0]          den_tol_i,
  input  wire [15:0]          param_tol_i,
  output pbl_pkg::stat_t      stat_o,
  output pbl_pkg::out_item_t  out_o
);
  import pbl_pkg::*;

  localparam int CntW = IdxW + 1;

  logic signed [31:0] mem_x [MaxVertices];
  logic signed [31:0] mem_y [MaxVertices];
  logic signed [31:0] mem_z [MaxVertices];
  logic [30:0]        mem_r [MaxVertices];
  logic               mem_s [MaxVertices];

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] rd_idx_q;   // index of next vertex to read
  logic [CntW-1:0] seg_idx_q;  // first vertex of current segment

  // vertex registers: r = last read, a = first of segment
  logic signed [31:0] rx_q, ry_q, rz_q;
  logic [30:0]        rr_q;
  logic               rs_q;
  logic signed [31:0] ax_q, ay_q, az_q;
  logic [30:0]        ar_q;

  logic signed [31:0] qx_q, qy_q, qz_q;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (in_fire_i && in_i.op == OP_LOAD && count_q < CntW'(MaxVertices)) begin
      mem_x[count_q[IdxW-1:0]] <= in_i.coord_x;
      mem_y[count_q[IdxW-1:0]] <= in_i.coord_y;
      mem_z[count_q[IdxW-1:0]] <= in_i.coord_z;
      mem_r[count_q[IdxW-1:0]] <= in_i.radius;
      mem_s[count_q[IdxW-1:0]] <= in_i.new_line;
    end
    if (cmd_i.rd_first || cmd_i.rd_next) begin
      rx_q <= mem_x[rd_idx_q[IdxW-1:0]];
      ry_q <= mem_y[rd_idx_q[IdxW-1:0]];
      rz_q <= mem_z[rd_idx_q[IdxW-1:0]];
      rr_q <= mem_r[rd_idx_q[IdxW-1:0]];
      rs_q <= mem_s[rd_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire_i && in_i.op == OP_CLEAR) begin
      count_q <= '0;
    end else if (in_fire_i && in_i.op == OP_LOAD && count_q < CntW'(MaxVertices)) begin
      count_q <= count_q + 1'b1;
    end
  end

  // segment arithmetic
  logic signed [33:0]  dx_q, dy_q, dz_q, vx_q, vy_q, vz_q; // 34-bit values
  logic signed [32:0]  dr_q;
  logic signed [31:0]  r0_q;
  logic                seg_ok_q, div_done_q;
  logic signed [69:0]  num_q, den_q;
  logic [69:0]         rem_q;
  logic [16:0]         t_q;
  logic [4:0]          bit_q;
  logic [1:0]          phase_q;

  logic signed [69:0] mul_a, mul_b, mul_c, mul_d;
  logic signed [69:0] den_w, num_w, den_abs, num_adj;
  always_comb begin
    mul_a = 70'(dx_q * dx_q) + 70'(dy_q * dy_q);
    mul_b = 70'(dz_q * dz_q) - 70'(dr_q * dr_q);
    mul_c = 70'(dx_q * vx_q) + 70'(dy_q * vy_q);
    mul_d = 70'(dz_q * vz_q) + 70'(dr_q * r0_q);
    den_w = mul_a + mul_b;
    num_w = mul_c + mul_d;
    den_abs = den_w[69] ? -den_w : den_w;
    num_adj = den_w[69] ? -num_w : num_w;
  end

  logic [69:0] rem_sh;
  always_comb rem_sh = {rem_q[68:0], 1'b0};

  // evaluation registers
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        cr_q;
  logic signed [69:0] val_w;
  logic signed [31:0] cx_w, cy_w, cz_w, cr_w;
  logic [16:0]        ts;

  function automatic logic signed [31:0] interp(input logic signed [31:0] base,
                                                input logic signed [33:0] dlt,
                                                input logic [16:0] t);
    logic signed [51:0] p;
    p = dlt * $signed({1'b0, t});
    interp = base + 32'(p >>> 16);
  endfunction

  always_comb begin
    ts = t_q;
    if (t_q < {1'b0, param_tol_i}) ts = '0;
    else if (PARAM_ONE - t_q < {1'b0, param_tol_i}) ts = PARAM_ONE;
    cx_w = interp(ax_q, dx_q, ts);
    cy_w = interp(ay_q, dy_q, ts);
    cz_w = interp(az_q, dz_q, ts);
    cr_w = interp(r0_q, 34'(dr_q), ts);
  end

  logic signed [33:0] ex, ey, ez;
  always_comb begin
    ex = 34'(qx_q) - 34'(cx_q);
    ey = 34'(qy_q) - 34'(cy_q);
    ez = 34'(qz_q) - 34'(cz_q);
  end

  logic signed [69:0] best_q;
  logic               found_q;
  logic [IdxW-1:0]    best_i_q;
  logic [16:0]        best_t_q, tsel_q;
  logic signed [31:0] best_cx_q, best_cy_q, best_cz_q;
  logic [30:0]        best_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      found_q  <= 1'b0;
      seg_ok_q <= 1'b0;
      div_done_q <= 1'b0;
    end else begin
      if (cmd_i.load_query) begin
        qx_q <= in_i.coord_x;
        qy_q <= in_i.coord_y;
        qz_q <= in_i.coord_z;
        rd_idx_q <= '0;
      end
      if (cmd_i.clr_best) found_q <= 1'b0;
      if (cmd_i.rd_first) rd_idx_q <= rd_idx_q + 1'b1;
      if (cmd_i.rd_next) begin
        // read data of previous read becomes first vertex
        ax_q <= rx_q; ay_q <= ry_q; az_q <= rz_q; ar_q <= rr_q;
        seg_idx_q <= rd_idx_q - 1'b1;
        rd_idx_q <= rd_idx_q + 1'b1;
        phase_q <= 2'd0;
      end
      if (cmd_i.seg_calc) begin
        dx_q <= 34'(rx_q) - 34'(ax_q);
        dy_q <= 34'(ry_q) - 34'(ay_q);
        dz_q <= 34'(rz_q) - 34'(az_q);
        vx_q <= 34'(qx_q) - 34'(ax_q);
        vy_q <= 34'(qy_q) - 34'(ay_q);
        vz_q <= 34'(qz_q) - 34'(az_q);
        r0_q <= use_radius_i ? $signed({1'b0, ar_q}) : 32'sd0;
        dr_q <= use_radius_i ? (33'($signed({1'b0, rr_q})) - 33'($signed({1'b0, ar_q})))
                             : 33'sd0;
        seg_ok_q <= !rs_q;
        div_done_q <= 1'b0;
        phase_q <= 2'd1;
      end
      if (cmd_i.div_step) begin
        if (phase_q == 2'd1) begin
          den_q <= den_abs;
          num_q <= num_adj;
          if (den_abs == '0 || den_abs < 70'(den_tol_i)) begin
            seg_ok_q <= 1'b0;
          end else if (num_adj[69] || num_adj == '0) begin
            t_q <= '0; div_done_q <= 1'b1;
          end else if (num_adj >= den_abs) begin
            t_q <= PARAM_ONE; div_done_q <= 1'b1;
          end else begin
            rem_q <= num_adj; t_q <= '0; bit_q <= '0; phase_q <= 2'd2;
          end
        end else begin
          if ($signed(rem_sh) >= den_q) begin
            rem_q <= rem_sh - den_q;
            t_q <= {t_q[15:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            t_q <= {t_q[15:0], 1'b0};
          end
          bit_q <= bit_q + 1'b1;
          if (bit_q == 5'd15) div_done_q <= 1'b1;
        end
      end
      if (cmd_i.eval) begin
        cx_q <= cx_w; cy_q <= cy_w; cz_q <= cz_w; cr_q <= cr_w[30:0];
        tsel_q <= ts;
      end
      if (cmd_i.update) begin
        if (!found_q || val_w < best_q) begin
          found_q <= 1'b1;
          best_q <= val_w;
          best_i_q <= seg_idx_q[IdxW-1:0];
          best_t_q <= tsel_q;
          best_cx_q <= cx_q;
          best_cy_q <= cy_q;
          best_cz_q <= cz_q;
          best_cr_q <= cr_q;
        end
      end
    end
  end

  always_comb begin
    val_w = 70'(ex * ex) + 70'(ey * ey) + 70'(ez * ez)
          - 70'($signed({1'b0, cr_q}) * $signed({1'b0, cr_q}));
  end

  logic signed [63:0] sat;
  always_comb begin
    if (best_q[69:63] == {7{best_q[63]}}) sat = best_q[63:0];
    else if (best_q[69]) sat = {1'b1, 63'd0};
    else sat = {1'b0, {63{1'b1}}};
  end

  assign out_o.min_value = found_q ? sat : {1'b0, {63{1'b1}}};
  assign out_o.found = found_q;
  assign out_o.segment_index = found_q ? best_i_q : '0;
  assign out_o.seg_param = found_q ? best_t_q : '0;
  assign out_o.center_x = found_q ? best_cx_q : '0;
  assign out_o.center_y = found_q ? best_cy_q : '0;
  assign out_o.center_z = found_q ? best_cz_q : '0;
  assign out_o.center_radius = found_q ? best_cr_q : '0;

  assign stat_o.more = rd_idx_q < count_q;
  assign stat_o.seg_valid = seg_ok_q;
  assign stat_o.div_done = div_done_q;
endmodule
`default_nettype wire

@@ design/polyball_line_min_distance.sv @@
`default_nettype none
// channel  dir  handshake                    payload
// in       in   in_valid_i / in_ready_o       in_item_t
// out      out  out_valid_o / out_ready_i     out_item_t
// cfg      in   cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
// load and clear complete as the item is accepted; a query walks the store one
// segment at a time through a multiply stage and a bit-serial divider: a segment
// cut by a line start is dropped before the divider, a degenerate one after its
// first divider step, and a clamped parameter skips the bit-serial steps
// reset empties the store and loads the register defaults; no clearing pass
// the input stalls while a query runs or its result waits
module polyball_line_min_distance #(
  parameter int MaxVertices = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  pbl_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output pbl_pkg::out_item_t  out_data_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [1:0]           cfg_index_i,
  input  wire [15:0]          cfg_data_i
);
  import pbl_pkg::*;

  localparam int IdxW = $clog2(MaxVertices);

  logic        use_radius_q;
  logic [15:0] den_tol_q, param_tol_q;
  cmd_t  cmd;
  stat_t stat;
  logic  busy, in_fire;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_radius_q <= 1'b1;
      den_tol_q <= 16'd1;
      param_tol_q <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_USE_RADIUS: use_radius_q <= cfg_data_i[0];
        CFG_DEN_TOL:    den_tol_q <= cfg_data_i;
        CFG_PARAM_TOL:  param_tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy;
  assign in_fire = in_valid_i && in_ready_o;

  pbl_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .start_i(in_fire && in_data_i.op == OP_QUERY),
    .out_ready_i(out_ready_i), .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .out_valid_o(out_valid_o)
  );

  pbl_dp #(.MaxVertices(MaxVertices), .IdxW(IdxW)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_data_i), .in_fire_i(in_fire),
    .cmd_i(cmd), .use_radius_i(use_radius_q), .den_tol_i(den_tol_q),
    .param_tol_i(param_tol_q), .stat_o(stat), .out_o(out_data_o)
  );
endmodule
`default_nettype wire
